/* src/byte_ring_length_prefix_deframer_core_defines.svh */
// Assertion macros for the byte ring deframer.
// Included by the top level; no other dependencies.
`ifndef BYTE_RING_LENGTH_PREFIX_DEFRAMER_CORE_DEFINES_SVH
`define BYTE_RING_LENGTH_PREFIX_DEFRAMER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BRLPD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);
`define BRLPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BRLPD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define BRLPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* src/brlpd_pkg.sv */
// Shared types and codes for the byte ring deframer.
// No dependencies.
package brlpd_pkg;

	localparam logic [1:0] MODE_PUSH      = 2'd0;
	localparam logic [1:0] MODE_PULL      = 2'd1;
	localparam logic [1:0] MODE_CLEAR     = 2'd2;
	localparam logic [1:0] MODE_CLEAR_ALT = 2'd3;

	localparam logic [2:0] STAT_PUSHED     = 3'd0;
	localparam logic [2:0] STAT_FULL       = 3'd1;
	localparam logic [2:0] STAT_INCOMPLETE = 3'd2;
	localparam logic [2:0] STAT_CORRUPT    = 3'd3;
	localparam logic [2:0] STAT_EMPTY      = 3'd4;
	localparam logic [2:0] STAT_PAYLOAD    = 3'd5;

	localparam int unsigned HDR_BYTES = 4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HDR,
		S_PAY
	} state_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  payload_byte;
		logic        last_byte;
		logic [12:0] fill_level;
	} result_t;

endpackage

/* src/brlpd_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module brlpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* src/byte_ring_length_prefix_deframer_core.sv */
// Top level of the byte ring deframer: control, pointers and result register.
// Depends on brlpd_pkg, brlpd_ram and the assertion macro header.
//
// A push, a clear, or a pull that is answered from the counters alone returns its
// result on done in the cycle after start is taken, and busy stays low, so such
// requests can be issued every cycle. A pull inside a packet reads one byte from
// the ring in S_PAY and returns it through the result register, with busy high for
// one cycle. A pull outside a packet with at least four bytes held reads the length
// header one byte per cycle in S_HDR through the ring's single read port: a rejected
// or empty header is reported through the result register when S_HDR ends, and the
// first payload byte of a new packet after a further S_PAY state. The result is
// shown for exactly one cycle and the receiver has no way to hold it.
`include "byte_ring_length_prefix_deframer_core_defines.svh"

module byte_ring_length_prefix_deframer_core #(
	parameter int RING_DEPTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  brlpd_pkg::cmd_t    cmd,
	output logic               done,
	output brlpd_pkg::result_t result
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int FW = $clog2(RING_DEPTH + 1);

	brlpd_pkg::state_t state_q, state_d;

	logic [FW-1:0]  fill_q, fill_d;
	logic [FW-1:0]  rem_q, rem_d;
	logic [AW-1:0]  rp_q, rp_d;
	logic [AW-1:0]  wp_q, wp_d;
	logic [AW-1:0]  ra_q, ra_d;
	logic [1:0]     cnt_q, cnt_d;
	logic [23:0]    len_q, len_d;
	logic           in_pkt_q, in_pkt_d;
	logic           done_q, done_d;
	brlpd_pkg::result_t result_q, result_d;

	logic           accept;
	logic           is_push;
	logic           is_pull;
	logic           is_clear;
	logic           full;
	logic           hdr_ready;
	logic           pkt_ok;
	logic [31:0]    hdr_len;
	logic           hdr_corrupt;
	logic           hdr_short;
	logic           hdr_zero;
	logic           hdr_start;
	logic           ram_we;
	logic [AW-1:0]  ram_raddr;
	logic [7:0]     ram_rdata;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign busy     = (state_q != brlpd_pkg::S_IDLE);
	assign accept   = start && !busy;
	assign is_push  = (cmd.mode == brlpd_pkg::MODE_PUSH);
	assign is_pull  = (cmd.mode == brlpd_pkg::MODE_PULL);
	assign is_clear = (cmd.mode == brlpd_pkg::MODE_CLEAR) ||
		(cmd.mode == brlpd_pkg::MODE_CLEAR_ALT);
	assign full      = (fill_q == FW'(RING_DEPTH));
	assign hdr_ready = (fill_q >= FW'(brlpd_pkg::HDR_BYTES));
	assign pkt_ok    = (fill_q != '0) && (rem_q != '0);

	assign hdr_len     = {len_q, ram_rdata};
	assign hdr_corrupt = hdr_len[31] || (hdr_len > 32'(RING_DEPTH));
	assign hdr_short   = hdr_len > (32'(fill_q) - 32'(brlpd_pkg::HDR_BYTES));
	assign hdr_zero    = (hdr_len == '0);
	assign hdr_start   = !hdr_corrupt && !hdr_short && !hdr_zero;

	assign ram_we    = accept && is_push && !full;
	assign ram_raddr = (state_q == brlpd_pkg::S_IDLE) ? rp_q : ra_q;

	brlpd_ram #(
		.WIDTH(8),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata(cmd.data_byte),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			brlpd_pkg::S_IDLE: begin
				if (accept && is_pull) begin
					if (in_pkt_q) begin
						if (pkt_ok) begin
							state_d = brlpd_pkg::S_PAY;
						end
					end else if (hdr_ready) begin
						state_d = brlpd_pkg::S_HDR;
					end
				end
			end
			brlpd_pkg::S_HDR: begin
				if (cnt_q == 2'd3) begin
					state_d = hdr_start ? brlpd_pkg::S_PAY : brlpd_pkg::S_IDLE;
				end
			end
			brlpd_pkg::S_PAY: begin
				state_d = brlpd_pkg::S_IDLE;
			end
			default: begin
				state_d = brlpd_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		fill_d   = fill_q;
		rem_d    = rem_q;
		rp_d     = rp_q;
		wp_d     = wp_q;
		ra_d     = ra_q;
		cnt_d    = cnt_q;
		len_d    = len_q;
		in_pkt_d = in_pkt_q;
		done_d   = 1'b0;
		result_d = result_q;
		result_d.payload_byte = '0;
		result_d.last_byte    = 1'b0;
		case (state_q)
			brlpd_pkg::S_IDLE: begin
				if (accept) begin
					done_d = 1'b1;
					result_d.status = brlpd_pkg::STAT_INCOMPLETE;
					if (is_clear) begin
						fill_d   = '0;
						rem_d    = '0;
						rp_d     = '0;
						wp_d     = '0;
						in_pkt_d = 1'b0;
						result_d.status = brlpd_pkg::STAT_PUSHED;
					end else if (is_push) begin
						if (full) begin
							result_d.status = brlpd_pkg::STAT_FULL;
						end else begin
							wp_d   = ptr_inc(wp_q);
							fill_d = fill_q + 1'b1;
							result_d.status = brlpd_pkg::STAT_PUSHED;
						end
					end else if (is_pull) begin
						if (in_pkt_q) begin
							if (pkt_ok) begin
								done_d = 1'b0;
							end else begin
								in_pkt_d = 1'b0;
								rem_d    = '0;
							end
						end else if (hdr_ready) begin
							done_d = 1'b0;
							ra_d   = ptr_inc(rp_q);
							cnt_d  = '0;
						end
					end
					result_d.fill_level = 13'(fill_d);
				end
			end
			brlpd_pkg::S_HDR: begin
				len_d = hdr_len[23:0];
				ra_d  = ptr_inc(ra_q);
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == 2'd3) begin
					ra_d = ra_q;
					if (hdr_corrupt) begin
						done_d = 1'b1;
						result_d.status = brlpd_pkg::STAT_CORRUPT;
					end else if (hdr_short) begin
						done_d = 1'b1;
						result_d.status = brlpd_pkg::STAT_INCOMPLETE;
					end else begin
						rp_d   = ra_q;
						fill_d = fill_q - FW'(brlpd_pkg::HDR_BYTES);
						if (hdr_zero) begin
							done_d = 1'b1;
							result_d.status = brlpd_pkg::STAT_EMPTY;
						end else begin
							in_pkt_d = 1'b1;
							rem_d    = FW'(hdr_len);
						end
					end
					result_d.fill_level = 13'(fill_d);
				end
			end
			brlpd_pkg::S_PAY: begin
				done_d = 1'b1;
				rp_d   = ptr_inc(rp_q);
				fill_d = fill_q - 1'b1;
				rem_d  = rem_q - 1'b1;
				if (rem_q == FW'(1)) begin
					in_pkt_d = 1'b0;
					result_d.last_byte = 1'b1;
				end
				result_d.status       = brlpd_pkg::STAT_PAYLOAD;
				result_d.payload_byte = ram_rdata;
				result_d.fill_level   = 13'(fill_d);
			end
			default: begin
				done_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= brlpd_pkg::S_IDLE;
			fill_q   <= '0;
			rem_q    <= '0;
			rp_q     <= '0;
			wp_q     <= '0;
			ra_q     <= '0;
			cnt_q    <= '0;
			in_pkt_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			rem_q    <= rem_d;
			rp_q     <= rp_d;
			wp_q     <= wp_d;
			ra_q     <= ra_d;
			cnt_q    <= cnt_d;
			in_pkt_q <= in_pkt_d;
			done_q   <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		len_q    <= len_d;
		result_q <= result_d;
	end

	assign done   = done_q;
	assign result = result_q;

	`BRLPD_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FW'(RING_DEPTH), "fill count above ring depth")
	`BRLPD_ASSERT_NOW(a_pkt_rem, clk, arst_n, in_pkt_q, rem_q != '0, "open packet with nothing remaining")
	`BRLPD_ASSERT_NOW(a_last_payload, clk, arst_n, done && result.last_byte, result.status == brlpd_pkg::STAT_PAYLOAD, "last flag on a non-payload result")
	`BRLPD_ASSERT_NEXT(a_pay_done, clk, arst_n, state_q == brlpd_pkg::S_PAY, done && !busy, "payload read did not produce a result")

endmodule

/* tb/sv/tb_byte_ring_length_prefix_deframer_core.sv */
// Testbench for the byte ring deframer: a queue-fed driver, a monitor that predicts
// each result from its own ring model, and directed, random and long-packet traffic.
// Depends on brlpd_pkg and byte_ring_length_prefix_deframer_core.
module tb_byte_ring_length_prefix_deframer_core;
	import brlpd_pkg::*;

	localparam int RING_BYTES = 4096;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_CAP = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic done;
	result_t result;

	cmd_t pending_reqs[$];
	result_t expected_results[$];
	logic taken = 1'b0;
	int unsigned idle_pct = 0;
	int reqs_queued = 0;
	int reqs_taken = 0;
	int results_checked = 0;
	int packets_done = 0;
	int errors = 0;
	int cycles = 0;
	int status_seen[8];

	logic [7:0] ring_bytes[RING_BYTES];
	logic [11:0] head = '0;
	logic [12:0] held = '0;
	logic in_pkt = 1'b0;
	logic [12:0] pay_left = '0;

	byte_ring_length_prefix_deframer_core #(
		.RING_DEPTH(RING_BYTES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t take_payload();
		result_t r;
		r = '0;
		r.status = STAT_PAYLOAD;
		r.payload_byte = ring_bytes[head];
		head = head + 12'd1;
		held = held - 13'd1;
		pay_left = pay_left - 13'd1;
		r.last_byte = (pay_left == 0);
		if (r.last_byte) begin
			in_pkt = 1'b0;
		end
		return r;
	endfunction

	function automatic result_t frame_step(cmd_t c);
		result_t r;
		logic [31:0] len;
		logic [11:0] idx;
		r = '0;
		len = '0;
		r.status = STAT_INCOMPLETE;
		if (c.mode == MODE_CLEAR || c.mode == MODE_CLEAR_ALT) begin
			head = '0;
			held = '0;
			in_pkt = 1'b0;
			pay_left = '0;
			r.status = STAT_PUSHED;
		end else if (c.mode == MODE_PUSH) begin
			if (held >= RING_BYTES) begin
				r.status = STAT_FULL;
			end else begin
				idx = head + held[11:0];
				ring_bytes[idx] = c.data_byte;
				held = held + 13'd1;
				r.status = STAT_PUSHED;
			end
		end else if (in_pkt) begin
			if (held == 0 || pay_left == 0) begin
				in_pkt = 1'b0;
				pay_left = '0;
			end else begin
				r = take_payload();
			end
		end else if (held >= HDR_BYTES) begin
			for (int i = 0; i < HDR_BYTES; i++) begin
				idx = head + 12'(i);
				len = {len[23:0], ring_bytes[idx]};
			end
			if (len[31] || len > RING_BYTES) begin
				r.status = STAT_CORRUPT;
			end else if (len + HDR_BYTES > held) begin
				r.status = STAT_INCOMPLETE;
			end else if (len == 0) begin
				head = head + 12'(HDR_BYTES);
				held = held - 13'(HDR_BYTES);
				r.status = STAT_EMPTY;
			end else begin
				head = head + 12'(HDR_BYTES);
				held = held - 13'(HDR_BYTES);
				in_pkt = 1'b1;
				pay_left = len[12:0];
				r = take_payload();
			end
		end
		r.fill_level = held;
		return r;
	endfunction

	task automatic flag_error(string what);
		errors++;
		if (errors <= PRINT_CAP) begin
			$display("Mismatch at cycle %0d: %s", cycles, what);
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || taken) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
				cmd <= pending_reqs.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			taken = 1'b0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					flag_error($sformatf("result %h with no request outstanding", result));
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (result.status !== want.status) begin
						flag_error($sformatf("status %0d, expected %0d",
							result.status, want.status));
					end
					if (result.payload_byte !== want.payload_byte) begin
						flag_error($sformatf("payload_byte %h, expected %h",
							result.payload_byte, want.payload_byte));
					end
					if (result.last_byte !== want.last_byte) begin
						flag_error($sformatf("last_byte %b, expected %b",
							result.last_byte, want.last_byte));
					end
					if (result.fill_level !== want.fill_level) begin
						flag_error($sformatf("fill_level %0d, expected %0d",
							result.fill_level, want.fill_level));
					end
				end
			end
			taken = start && !busy;
			if (taken) begin
				want = frame_step(cmd);
				expected_results.push_back(want);
				reqs_taken++;
				status_seen[want.status]++;
				if (want.last_byte) begin
					packets_done++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycles,
				expected_results.size());
			$display("FAIL");
			$finish;
		end
	end

	task automatic add_req(logic [1:0] m, logic [7:0] d);
		cmd_t c;
		c.mode = m;
		c.data_byte = d;
		pending_reqs.push_back(c);
		reqs_queued++;
	endtask

	task automatic add_header(logic [31:0] len);
		for (int i = 3; i >= 0; i--) begin
			add_req(MODE_PUSH, len[8 * i +: 8]);
		end
	endtask

	task automatic add_clear();
		add_req(($urandom_range(1) != 0) ? MODE_CLEAR : MODE_CLEAR_ALT, 8'($urandom));
	endtask

	// Pushes of one or more framed packets mixed with the pulls that drain them.
	task automatic add_packet_burst();
		logic [7:0] bytes_out[$];
		int npkts;
		int len;
		int pulls;
		int sel;
		pulls = $urandom_range(0, 2);
		npkts = $urandom_range(1, 3);
		for (int p = 0; p < npkts; p++) begin
			sel = $urandom_range(99);
			if (sel < 8) begin
				len = 0;
			end else if (sel < 85) begin
				len = $urandom_range(1, 16);
			end else begin
				len = $urandom_range(17, 200);
			end
			for (int i = 3; i >= 0; i--) begin
				bytes_out.push_back(8'(len >> (8 * i)));
			end
			for (int i = 0; i < len; i++) begin
				bytes_out.push_back(8'($urandom));
			end
			pulls += (len == 0) ? 1 : len;
		end
		while (bytes_out.size() != 0 || pulls != 0) begin
			if (bytes_out.size() != 0 && (pulls == 0 || $urandom_range(99) < 75)) begin
				add_req(MODE_PUSH, bytes_out.pop_front());
			end else begin
				add_req(MODE_PULL, 8'($urandom));
				pulls--;
			end
		end
	endtask

	task automatic add_bad_header();
		logic [31:0] len;
		len = $urandom;
		if ($urandom_range(1) != 0) begin
			len[31] = 1'b1;
		end else begin
			len = 32'($urandom_range(RING_BYTES + 1, 32'h7fff_ffff));
		end
		add_header(len);
		repeat ($urandom_range(1, 2)) add_req(MODE_PULL, 8'($urandom));
		if ($urandom_range(1) != 0) begin
			add_clear();
		end
	endtask

	task automatic add_noise();
		repeat ($urandom_range(2, 8)) add_req(2'($urandom_range(3)), 8'($urandom));
		if ($urandom_range(99) < 60) begin
			add_clear();
		end
	endtask

	task automatic add_random(int n);
		int goal;
		int sel;
		goal = reqs_queued + n;
		while (reqs_queued < goal) begin
			sel = $urandom_range(99);
			if (sel < 70) begin
				add_packet_burst();
			end else if (sel < 80) begin
				add_clear();
			end else if (sel < 90) begin
				add_noise();
			end else begin
				add_bad_header();
			end
		end
	endtask

	task automatic add_big_packet(int len, int extra_pushes);
		add_header(32'(len));
		repeat (len) add_req(MODE_PUSH, 8'($urandom));
		repeat (extra_pushes) add_req(MODE_PUSH, 8'($urandom));
		repeat (len + 1) add_req(MODE_PULL, 8'($urandom));
	endtask

	task automatic add_directed();
		add_req(MODE_PULL, 8'h00);
		add_header(32'h0000_0000);
		add_req(MODE_PULL, 8'hff);
		add_header(32'h8000_0000);
		add_req(MODE_PULL, 8'h00);
		add_req(MODE_CLEAR_ALT, 8'hff);
		add_header(32'(RING_BYTES));
		add_req(MODE_PULL, 8'h00);
		add_req(MODE_CLEAR, 8'h00);
		add_header(32'h0000_0002);
		add_req(MODE_PUSH, 8'hff);
		add_req(MODE_PULL, 8'h00);
		add_req(MODE_PUSH, 8'h00);
		add_req(MODE_PULL, 8'h00);
		add_req(MODE_PULL, 8'h00);
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || start || expected_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		idle_pct = 15;
		add_directed();
		add_random(400);
		wait_drained();

		idle_pct = 77;
		add_random(400);
		wait_drained();

		idle_pct = 0;
		add_random(400);
		add_clear();
		add_big_packet(120, 0);
		add_big_packet(40, 2);
		wait_drained();

		repeat (12) @(posedge clk);
		if (expected_results.size() != 0) begin
			flag_error($sformatf("%0d expected results never arrived",
				expected_results.size()));
		end
		$display("Checked %0d results of %0d requests: %0d pushed or cleared, %0d dropped full,",
			results_checked, reqs_taken, status_seen[STAT_PUSHED], status_seen[STAT_FULL]);
		$display("%0d incomplete, %0d corrupt, %0d empty packets, %0d payload bytes, %0d packets.",
			status_seen[STAT_INCOMPLETE], status_seen[STAT_CORRUPT], status_seen[STAT_EMPTY],
			status_seen[STAT_PAYLOAD], packets_done);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

/* byte_ring_length_prefix_deframer_core.f */
+incdir+src
src/brlpd_pkg.sv
src/brlpd_ram.sv
src/byte_ring_length_prefix_deframer_core.sv
tb/sv/tb_byte_ring_length_prefix_deframer_core.sv
